>>> design/shamc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shamc_pkg
// Shared sizes, request codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package shamc_pkg;

    // lane count and lane field width
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    // store depths across all lanes and RAM address widths
    localparam int CHN_DEPTH = LANES * 8;
    localparam int BLK_DEPTH = LANES * 16;
    localparam int CHN_AW    = $clog2(CHN_DEPTH);
    localparam int BLK_AW    = $clog2(BLK_DEPTH);

    // request codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_MSG  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // last word position in the message block
    localparam logic [3:0] LAST_MSG_IDX = 4'd15;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_LOAD      = 6'b000010,
        ST_ROUND     = 6'b000100,
        ST_WB        = 6'b001000,
        ST_EMIT_RD   = 6'b010000,
        ST_EMIT_WAIT = 6'b100000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;     // input word taken this cycle
        logic       wr_chn_in;  // write input word into chaining store
        logic       wr_blk_in;  // write input word into block store
        logic       rd_blk;     // read block store at step count
        logic       rd_chn;     // read chaining store at step count
        logic       cap_w;      // shift block read data into schedule window
        logic       cap_v;      // shift chaining read data into working state
        logic       round;      // run one compression round
        logic       wb;         // write back feed-forward sum
        logic       load_out;   // load output register from chaining read
        logic [5:0] cnt;        // step count
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;         // output register can take a word
    } status_t;

endpackage

>>> design/shamc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shamc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds when no read is issued.
// ----------------------------------------------------------------------------
module shamc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/shamc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shamc_ctrl
// Sequencer: decodes accepted words and steps the datapath through block
// load, 64 rounds, feed-forward writeback and the eight-word state dump.
// ----------------------------------------------------------------------------
module shamc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [2:0]          lane,
    input  logic [3:0]          word_index,
    input  logic                final_block,
    input  shamc_pkg::status_t  status,
    output shamc_pkg::cmd_t     cmd
);

    shamc_pkg::state_t state_reg, state_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              fin_reg, fin_next;
    logic              lane_ok;

    assign in_ready = (state_reg == shamc_pkg::ST_IDLE);
    assign lane_ok  = (32'(lane) < shamc_pkg::LANES);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shamc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fin_reg   <= fin_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        case (state_reg)
            shamc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (lane_ok)
                    begin
                        case (req_type)
                            shamc_pkg::REQ_LOAD:
                            begin
                                cmd.wr_chn_in = ~word_index[3];
                            end
                            shamc_pkg::REQ_MSG:
                            begin
                                cmd.wr_blk_in = 1'b1;
                                if (word_index == shamc_pkg::LAST_MSG_IDX)
                                begin
                                    state_next = shamc_pkg::ST_LOAD;
                                    cnt_next   = '0;
                                    fin_next   = final_block;
                                end
                            end
                            shamc_pkg::REQ_READ:
                            begin
                                state_next = shamc_pkg::ST_EMIT_RD;
                                cnt_next   = '0;
                            end
                            default:
                            begin
                                // unused request code: drop the word
                            end
                        endcase
                    end
                end
            end
            shamc_pkg::ST_LOAD:
            begin
                // read block and chaining words, capture them in the cycle after
                cmd.rd_blk = (cnt_reg < 6'd16);
                cmd.rd_chn = (cnt_reg < 6'd8);
                cmd.cap_w  = (cnt_reg != 6'd0);
                cmd.cap_v  = (cnt_reg inside {[6'd1:6'd8]});
                if (cnt_reg == 6'd16)
                begin
                    state_next = shamc_pkg::ST_ROUND;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            shamc_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = shamc_pkg::ST_WB;
                end
            end
            shamc_pkg::ST_WB:
            begin
                cmd.wb = 1'b1;
                if (cnt_reg == 6'd7)
                begin
                    cnt_next   = '0;
                    state_next = fin_reg ? shamc_pkg::ST_EMIT_RD : shamc_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            shamc_pkg::ST_EMIT_RD:
            begin
                cmd.rd_chn = 1'b1;
                state_next = shamc_pkg::ST_EMIT_WAIT;
            end
            shamc_pkg::ST_EMIT_WAIT:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (cnt_reg == 6'd7)
                    begin
                        cnt_next   = '0;
                        state_next = shamc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 6'd1;
                        state_next = shamc_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = shamc_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // the load phase never runs past its last capture step
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shamc_pkg::ST_LOAD) |-> (cnt_reg <= 6'd16))
        else $error("load step count out of range");

    // accepted writes and writeback never share the chaining write port
    a_chn_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_chn_in && cmd.wb))
        else $error("chaining store write collision");

    // a dump word is loaded only when the output side can take it
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output register overwritten");

    // every dump wait follows a chaining store read
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shamc_pkg::ST_EMIT_WAIT) |->
            ($past(state_reg) == shamc_pkg::ST_EMIT_RD ||
             $past(state_reg) == shamc_pkg::ST_EMIT_WAIT))
        else $error("dump wait without read");

endmodule

>>> design/shamc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shamc_datapath
// Chaining and block stores, message schedule window, working state a..h,
// one SHA-256 round per cycle, feed-forward adder and output register.
// ----------------------------------------------------------------------------
module shamc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  shamc_pkg::cmd_t     cmd,
    output shamc_pkg::status_t  status,
    input  logic [2:0]          lane,
    input  logic [3:0]          word_index,
    input  logic [31:0]         data_word,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          out_lane,
    output logic [2:0]          out_index,
    output logic [31:0]         digest_word,
    output logic                last
);

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    logic [2:0]  lane_reg;
    logic [31:0] w_reg  [16];
    logic [31:0] v_reg  [8];
    logic [31:0] st_reg [8];

    logic        out_valid_reg;
    logic [2:0]  out_lane_reg;
    logic [2:0]  out_index_reg;
    logic [31:0] digest_reg;
    logic        last_reg;

    logic                         chn_we;
    logic [shamc_pkg::CHN_AW-1:0] chn_waddr;
    logic [31:0]                  chn_wdata;
    logic [shamc_pkg::CHN_AW-1:0] chn_raddr;
    logic [31:0]                  chn_rdata;
    logic [shamc_pkg::BLK_AW-1:0] blk_waddr;
    logic [shamc_pkg::BLK_AW-1:0] blk_raddr;
    logic [31:0]                  blk_rdata;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;
    logic [31:0] ff_sum;

    // chaining store write: input word or feed-forward sum
    assign chn_we    = cmd.wr_chn_in | cmd.wb;
    assign chn_waddr = cmd.wb ? shamc_pkg::CHN_AW'({lane_reg, cmd.cnt[2:0]})
                              : shamc_pkg::CHN_AW'({lane, word_index[2:0]});
    assign chn_wdata = cmd.wb ? ff_sum : data_word;
    assign chn_raddr = shamc_pkg::CHN_AW'({lane_reg, cmd.cnt[2:0]});

    assign blk_waddr = shamc_pkg::BLK_AW'({lane, word_index});
    assign blk_raddr = shamc_pkg::BLK_AW'({lane_reg, cmd.cnt[3:0]});

    shamc_ram #(
        .WIDTH (32),
        .DEPTH (shamc_pkg::CHN_DEPTH)
    ) u_chn_ram (
        .clk   (clk),
        .we    (chn_we),
        .waddr (chn_waddr),
        .wdata (chn_wdata),
        .re    (cmd.rd_chn),
        .raddr (chn_raddr),
        .rdata (chn_rdata)
    );

    shamc_ram #(
        .WIDTH (32),
        .DEPTH (shamc_pkg::BLK_DEPTH)
    ) u_blk_ram (
        .clk   (clk),
        .we    (cmd.wr_blk_in),
        .waddr (blk_waddr),
        .wdata (data_word),
        .re    (cmd.rd_blk),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    // round arithmetic and schedule expansion
    assign t1 = v_reg[7] + big_sig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[cmd.cnt] + w_reg[0];
    assign t2 = big_sig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new  = w_reg[0] + small_sig0(w_reg[1]) + w_reg[9] + small_sig1(w_reg[14]);
    assign ff_sum = st_reg[cmd.cnt[2:0]] + v_reg[cmd.cnt[2:0]];

    // lane of the word in progress
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            lane_reg <= lane;
        end
    end

    // schedule window: fill from block store, then slide each round
    always_ff @(posedge clk)
    begin
        if (cmd.cap_w || cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= cmd.round ? w_new : blk_rdata;
        end
    end

    // working and saved state: fill both from chaining store; working state advances each round
    always_ff @(posedge clk)
    begin
        if (cmd.cap_v)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_reg[i]  <= v_reg[i+1];
                st_reg[i] <= st_reg[i+1];
            end
            v_reg[7]  <= chn_rdata;
            st_reg[7] <= chn_rdata;
        end
        else if (cmd.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_lane_reg  <= lane_reg;
            out_index_reg <= cmd.cnt[2:0];
            digest_reg    <= chn_rdata;
            last_reg      <= (cmd.cnt[2:0] == 3'd7);
        end
    end

    assign status.out_free = ~out_valid_reg | out_ready;

    assign out_valid   = out_valid_reg;
    assign out_lane    = out_lane_reg;
    assign out_index   = out_index_reg;
    assign digest_word = digest_reg;
    assign last        = last_reg;

endmodule

>>> design/sha256_multilane_compression.sv
`timescale 1ns / 1ps
// Input: load, message and read words are taken while the sequencer is idle;
//   message word 15 holds the input through load, 64 rounds and writeback.
// Throughput: one round per cycle in the shared round unit; state dumps read
//   each word before loading it and stall while the output register is full.
// Reset: rst_n clears the sequencer and output valid; the chaining and block
//   stores keep no reset and are undefined until written.
// ----------------------------------------------------------------------------
// sha256_multilane_compression
// Multi-lane SHA-256 compression: per-lane chaining state and block buffer,
// compression with feed-forward on word 15, eight-word state dumps.
// ----------------------------------------------------------------------------
module sha256_multilane_compression (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [2:0]  lane,
    input  logic [3:0]  word_index,
    input  logic [31:0] data_word,
    input  logic        final_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_lane,
    output logic [2:0]  out_index,
    output logic [31:0] digest_word,
    output logic        last
);

    shamc_pkg::cmd_t    cmd;
    shamc_pkg::status_t status;

    // sequencer
    shamc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .lane        (lane),
        .word_index  (word_index),
        .final_block (final_block),
        .status      (status),
        .cmd         (cmd)
    );

    // stores, round unit and output register
    shamc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .lane        (lane),
        .word_index  (word_index),
        .data_word   (data_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_lane    (out_lane),
        .out_index   (out_index),
        .digest_word (digest_word),
        .last        (last)
    );

endmodule
